### src/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg: shared types and constants of the LRU page replacement core
// Field widths of the stream channels, build defaults and the command bundle
// that the controller drives into the datapath.
// ----------------------------------------------------------------------------
package lrupr_pkg;

   // build defaults
   localparam int MaxFramesDefault = 8;
   localparam int PageBitsDefault  = 8;

   // fixed field widths of the channels
   localparam int ReqPageW    = 8;
   localparam int FrameCountW = 4;
   localparam int SlotW       = 3;
   localparam int EvictPageW  = 8;
   localparam int FaultTotalW = 16;
   localparam int ResidentW   = 4;
   localparam int ReqDataW    = 8;
   localparam int RspDataW    = 32;

   localparam logic [FrameCountW-1:0] FrameCountReset = 4'd8;

   // commands from controller to datapath
   typedef struct packed {
      logic load_req;   // capture the page of an accepted transaction
      logic look;       // register match and LRU vectors
      logic commit;     // update the table and load the response register
   } lrupr_cmd_type;

endpackage

### src/lrupr_ctrl.sv
// ----------------------------------------------------------------------------
// lrupr_ctrl: sequencing controller
// Accepts one reference, runs the lookup step, then commits it once the
// response register is free. Owns the handshake flags of both channels.
// ----------------------------------------------------------------------------
module lrupr_ctrl
   import lrupr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output lrupr_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the previous response has left
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/lrupr_datapath.sv
// ----------------------------------------------------------------------------
// lrupr_datapath: frame table, recency ranks, counters and response register
// Each slot keeps its page and a rank (0 = least recent). Lookup compares all
// occupied slots in parallel; commit touches one slot and shifts the ranks.
// ----------------------------------------------------------------------------
module lrupr_datapath
   import lrupr_pkg::*;
#(
   parameter int MAX_FRAMES = MaxFramesDefault,
   parameter int PAGE_BITS  = PageBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lrupr_cmd_type          cmd,
   input  logic [ReqPageW-1:0]    req_page,
   input  logic                   csr_wr_en,
   input  logic [FrameCountW-1:0] csr_wr_data,
   output logic                   rsp_fault,
   output logic [SlotW-1:0]       rsp_slot,
   output logic                   rsp_evicted_valid,
   output logic [EvictPageW-1:0]  rsp_evicted_page,
   output logic [FaultTotalW-1:0] rsp_fault_total,
   output logic [ResidentW-1:0]   rsp_resident_count
);

   localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int LIM_W  = (CNT_W > FrameCountW) ? CNT_W : FrameCountW;
   localparam int PG_XW  = (PAGE_BITS > ReqPageW) ? PAGE_BITS : ReqPageW;
   localparam int SL_XW  = (SLOT_W > SlotW) ? SLOT_W : SlotW;
   localparam int RC_XW  = (CNT_W > ResidentW) ? CNT_W : ResidentW;

   // table state
   logic [PAGE_BITS-1:0]   page_ff [MAX_FRAMES];
   logic [PAGE_BITS-1:0]   page_in [MAX_FRAMES];
   logic [SLOT_W-1:0]      rank_ff [MAX_FRAMES];
   logic [SLOT_W-1:0]      rank_in [MAX_FRAMES];
   logic [CNT_W-1:0]       occ_ff, occ_in;
   logic [FaultTotalW-1:0] faults_ff, faults_in;
   logic [FrameCountW-1:0] frame_count_ff;

   // per-transaction registers
   logic [PAGE_BITS-1:0]   cur_page_ff;
   logic [MAX_FRAMES-1:0]  hit_vec_ff, lru_vec_ff;
   logic                   full_ff;

   // response register
   logic                   fault_ff;
   logic [SlotW-1:0]       slot_ff;
   logic                   ev_valid_ff;
   logic [EvictPageW-1:0]  ev_page_ff;
   logic [ResidentW-1:0]   resident_ff;

   logic [PG_XW-1:0]       req_page_x, ev_page_x;
   logic [PAGE_BITS-1:0]   ev_page;
   logic [MAX_FRAMES-1:0]  hit_vec, lru_vec, sel_vec;
   logic [LIM_W-1:0]       limit;
   logic                   hit, fill, evict;
   logic [SLOT_W-1:0]      sel_slot, sel_rank, occ_m1, tgt_slot;
   logic [SL_XW-1:0]       slot_x;
   logic [RC_XW-1:0]       occ_x;

   assign req_page_x = PG_XW'(req_page);

   // clamp the frame limit into 1..MAX_FRAMES
   always_comb begin
      if (frame_count_ff == '0) begin
         limit = LIM_W'(1);
      end else if (LIM_W'(frame_count_ff) > LIM_W'(MAX_FRAMES)) begin
         limit = LIM_W'(MAX_FRAMES);
      end else begin
         limit = LIM_W'(frame_count_ff);
      end
   end

   // parallel match over occupied slots
   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         hit_vec[i] = (CNT_W'(i) < occ_ff) && (page_ff[i] == cur_page_ff);
         lru_vec[i] = (CNT_W'(i) < occ_ff) && (rank_ff[i] == '0);
      end
   end

   assign hit   = |hit_vec_ff;
   assign fill  = !hit && !full_ff;
   assign evict = !hit && full_ff;
   assign sel_vec = hit ? hit_vec_ff : lru_vec_ff;
   assign occ_m1  = SLOT_W'(occ_ff - CNT_W'(1));

   // one-hot encode of the touched slot, its rank and its page
   always_comb begin
      sel_slot = '0;
      sel_rank = '0;
      ev_page  = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         if (sel_vec[i]) begin
            sel_slot = sel_slot | SLOT_W'(i);
            sel_rank = sel_rank | rank_ff[i];
            ev_page  = ev_page | page_ff[i];
         end
      end
   end

   assign tgt_slot  = fill ? occ_ff[SLOT_W-1:0] : sel_slot;
   assign ev_page_x = evict ? PG_XW'(ev_page) : '0;
   assign slot_x    = SL_XW'(tgt_slot);

   always_comb begin
      occ_in    = fill ? occ_ff + CNT_W'(1) : occ_ff;
      faults_in = faults_ff;
      if (!hit && (faults_ff != '1)) begin
         faults_in = faults_ff + FaultTotalW'(1);
      end
      for (int i = 0; i < MAX_FRAMES; i++) begin
         page_in[i] = page_ff[i];
         rank_in[i] = rank_ff[i];
         if (fill) begin
            if (CNT_W'(i) == occ_ff) begin
               page_in[i] = cur_page_ff;
               rank_in[i] = occ_ff[SLOT_W-1:0];
            end
         end else if (sel_vec[i]) begin
            // touched slot becomes most recent
            rank_in[i] = occ_m1;
            if (evict) begin
               page_in[i] = cur_page_ff;
            end
         end else if ((CNT_W'(i) < occ_ff) && (rank_ff[i] > sel_rank)) begin
            rank_in[i] = rank_ff[i] - SLOT_W'(1);
         end
      end
   end

   assign occ_x = RC_XW'(occ_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff         <= '0;
         faults_ff      <= '0;
         frame_count_ff <= FrameCountReset;
      end else begin
         if (csr_wr_en) begin
            frame_count_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            occ_ff    <= occ_in;
            faults_ff <= faults_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cur_page_ff <= req_page_x[PAGE_BITS-1:0];
      end
      if (cmd.look) begin
         hit_vec_ff <= hit_vec;
         lru_vec_ff <= lru_vec;
         full_ff    <= (LIM_W'(occ_ff) >= limit);
      end
      if (cmd.commit) begin
         for (int i = 0; i < MAX_FRAMES; i++) begin
            page_ff[i] <= page_in[i];
            rank_ff[i] <= rank_in[i];
         end
         fault_ff    <= !hit;
         slot_ff     <= slot_x[SlotW-1:0];
         ev_valid_ff <= evict;
         ev_page_ff  <= ev_page_x[EvictPageW-1:0];
         resident_ff <= occ_x[ResidentW-1:0];
      end
   end

   assign rsp_fault          = fault_ff;
   assign rsp_slot           = slot_ff;
   assign rsp_evicted_valid  = ev_valid_ff;
   assign rsp_evicted_page   = ev_page_ff;
   assign rsp_fault_total    = faults_ff;
   assign rsp_resident_count = resident_ff;

endmodule

### src/lru_page_replacement_core.sv
// ----------------------------------------------------------------------------
// lru_page_replacement_core: fully associative page-frame table with LRU
// Takes one page reference per transaction and returns one response telling
// hit or fault, the slot used, any evicted page, the running fault total and
// the number of resident pages.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+----------------------------------------------------
//  req_*    | in        | tdata[7:0] page_number
//  rsp_*    | out       | tuser fault; tdata slot/evicted/fault_total/resident
//  csr_*    | in        | frame_count, written on csr_wr_en
//
//  Steps: each reference passes accept, lookup and commit; the parallel compare
//  over all slots is registered before the table update. A new reference is
//  accepted only after the previous one has committed.
//  Reset: synchronous; clears resident count, fault total and handshake state,
//  and sets frame_count to 8. Page and rank stores are filled as pages arrive.
//  Stalls: a new reference is accepted while a response still waits; its
//  commit holds until rsp_tready drains the response register.
// ----------------------------------------------------------------------------
module lru_page_replacement_core
   import lrupr_pkg::*;
#(
   parameter int MAX_FRAMES = MaxFramesDefault,
   parameter int PAGE_BITS  = PageBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   // reference stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [ReqDataW-1:0]    req_tdata,    // [7:0] page_number
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RspDataW-1:0]    rsp_tdata,    // [2:0] slot, [3] evicted_valid,
                                                // [11:4] evicted_page,
                                                // [27:12] fault_total,
                                                // [31:28] resident_count
   output logic                   rsp_tuser,    // [0] fault
   // frame limit register
   input  logic                   csr_wr_en,
   input  logic [FrameCountW-1:0] csr_wr_data
);

   lrupr_cmd_type          cmd;
   logic [SlotW-1:0]       slot;
   logic                   ev_valid;
   logic [EvictPageW-1:0]  ev_page;
   logic [FaultTotalW-1:0] fault_total;
   logic [ResidentW-1:0]   resident;

   // sequence each transaction and own the handshake flags
   lrupr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // table, ranks, counters and response register
   lrupr_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_page           (req_tdata[ReqPageW-1:0]),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_fault          (rsp_tuser),
      .rsp_slot           (slot),
      .rsp_evicted_valid  (ev_valid),
      .rsp_evicted_page   (ev_page),
      .rsp_fault_total    (fault_total),
      .rsp_resident_count (resident)
   );

   // pack response fields, slot in the lowest bits
   assign rsp_tdata = {resident, fault_total, ev_page, ev_valid, slot};

endmodule

### src/lrupr_checker.sv
// ----------------------------------------------------------------------------
// lrupr_checker: port-level checks of the LRU page replacement core
// Watches the response channel for consistency of its fields over time.
// ----------------------------------------------------------------------------
module lrupr_checker
   import lrupr_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RspDataW-1:0]    rsp_tdata,
   input logic                   rsp_tuser
);

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response offered after reset");

   // a hit never evicts
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> !rsp_tdata[3])
      else $error("eviction reported on a hit");

   // without an eviction the evicted page reads zero
   a_evict_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[3] |-> (rsp_tdata[11:4] == '0))
      else $error("evicted page nonzero without eviction");

   // an eviction only happens with at least one resident page
   a_evict_resident: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> (rsp_tdata[31:28] != '0))
      else $error("eviction with empty table");

endmodule

bind lru_page_replacement_core lrupr_checker u_lrupr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
